>>> rtl/core/scrp_pkg.sv
package scrp_pkg;

    // Default scan length limit
    localparam int MAX_BEAMS_DEF = 2048;

    // CORDIC word: x, y and z share one signed width
    localparam int CW       = 36;
    localparam int CORDIC_N = 24;

    typedef logic signed [CW-1:0] t_cw;

    localparam t_cw C_PI  = 36'sd1686629713;
    localparam t_cw C_HPI = 36'sd843314857;
    localparam t_cw C_2PI = 36'sd3373259426;
    localparam t_cw C_K   = 36'sd652032874;

    // Register indexes
    localparam logic [2:0] REG_THR   = 3'd0;
    localparam logic [2:0] REG_MINB  = 3'd1;
    localparam logic [2:0] REG_EXP   = 3'd2;
    localparam logic [2:0] REG_TOL   = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;
    localparam logic [2:0] REG_STEP  = 3'd5;

    // Register reset values
    localparam logic [15:0]        RST_THR   = 16'd8000;
    localparam logic [11:0]        RST_MINB  = 12'd5;
    localparam logic [16:0]        RST_EXP   = 17'd600;
    localparam logic [16:0]        RST_TOL   = 17'd150;
    localparam logic signed [31:0] RST_START = -32'sd1686629713;
    localparam logic [29:0]        RST_STEP  = 30'd3123374;

    // Result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_FEW     = 2'd1;
    localparam logic [1:0] ST_SPACING = 2'd2;

    // Request to the shared CORDIC unit
    typedef struct packed {
        logic start;
        logic vec;
    } t_cord_req;

    // Arctangent of 2^-i, radians Q2.29
    function automatic logic [29:0] f_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd421657428;
            5'd1:    v = 30'd248918915;
            5'd2:    v = 30'd131521918;
            5'd3:    v = 30'd66762579;
            5'd4:    v = 30'd33510843;
            5'd5:    v = 30'd16771758;
            5'd6:    v = 30'd8387925;
            5'd7:    v = 30'd4194219;
            5'd8:    v = 30'd2097141;
            5'd9:    v = 30'd1048575;
            5'd10:   v = 30'd524288;
            5'd11:   v = 30'd262144;
            5'd12:   v = 30'd131072;
            5'd13:   v = 30'd65536;
            5'd14:   v = 30'd32768;
            5'd15:   v = 30'd16384;
            5'd16:   v = 30'd8192;
            5'd17:   v = 30'd4096;
            5'd18:   v = 30'd2048;
            5'd19:   v = 30'd1024;
            5'd20:   v = 30'd512;
            5'd21:   v = 30'd256;
            5'd22:   v = 30'd128;
            5'd23:   v = 30'd64;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/scrp_cordic.sv
module scrp_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scrp_pkg::t_cord_req i_req,
    input  scrp_pkg::t_cw       i_x,
    input  scrp_pkg::t_cw       i_y,
    input  scrp_pkg::t_cw       i_z,
    output logic                o_done,
    output scrp_pkg::t_cw       o_x,
    output scrp_pkg::t_cw       o_y,
    output scrp_pkg::t_cw       o_z
);
    import scrp_pkg::*;

    logic       r_busy;
    logic       r_done;
    logic       r_vec;
    logic [4:0] r_it;
    t_cw        r_x;
    t_cw        r_y;
    t_cw        r_z;

    t_cw  w_xs;
    t_cw  w_ys;
    t_cw  w_at;
    logic w_up;

    // One micro-rotation: floor shifts, direction from z or from y
    always_comb begin
        w_xs = r_x >>> r_it;
        w_ys = r_y >>> r_it;
        w_at = t_cw'(f_atan(r_it));
        w_up = r_vec ? !(r_y > 0) : !r_z[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_vec  <= 1'b0;
            r_it   <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_vec  <= i_req.vec;
                r_it   <= 5'd0;
            end else if (r_busy) begin
                r_it <= r_it + 5'd1;
                if (r_it == 5'(CORDIC_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            r_x <= w_up ? r_x - w_ys : r_x + w_ys;
            r_y <= w_up ? r_y + w_xs : r_y - w_xs;
            r_z <= w_up ? r_z - w_at : r_z + w_at;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

>>> rtl/core/scan_reflector_pair_detector.sv
// Reflector pair detector for one lidar scan.
// Beam words enter on i_valid/o_ready (intensity, range, last-beam mark); one
// result word per scan leaves on o_valid/i_ready after the last beam.
// The user writes configuration over the APB port only between words; the
// block does not enforce it, and pready is tied high. Work after a beam word:
//   beam below threshold, past the beam limit or beyond the second cluster:
//   no further work, so such words can follow back to back.
//   beam inside one of the first two clusters: the angle reduction (one
//   compare and subtract per index bit) and 24 iterations of the shared CORDIC
//   unit.
//   last beam: the result takes at most four 33-step centroid divisions,
//   two 19-step square roots and a 24-step CORDIC vectoring pass.
// The block takes no beam word while it works on one. A result waiting for
// i_ready holds; the next scan's beams are taken meanwhile, and the next
// result is not built until the waiting one has gone.
// Reset loads the default registers and clears all scan state; no clearing
// pass is needed.
module scan_reflector_pair_detector #(
    parameter int MAX_BEAMS = scrp_pkg::MAX_BEAMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_intensity,
    input  logic [15:0]        i_range_mm,
    input  logic               i_last_beam,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_legs_found,
    output logic [1:0]         o_status,
    output logic [16:0]        o_leg_spacing_mm,
    output logic signed [16:0] o_midpoint_x_mm,
    output logic signed [16:0] o_midpoint_y_mm,
    output logic [15:0]        o_midpoint_distance_mm,
    output logic signed [31:0] o_midpoint_angle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import scrp_pkg::*;

    localparam int IW  = $clog2(MAX_BEAMS + 1);
    localparam int PW  = IW + 30;
    localparam int KW  = $clog2(IW);
    localparam int CMW = (IW > 12) ? IW : 12;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_MUL  = 20'h00002,
        S_MOD  = 20'h00004,
        S_FOLD = 20'h00008,
        S_ROT  = 20'h00010,
        S_ROTW = 20'h00020,
        S_ACX  = 20'h00040,
        S_ACY  = 20'h00080,
        S_EVAL = 20'h00100,
        S_DIVI = 20'h00200,
        S_DIVR = 20'h00400,
        S_DIVE = 20'h00800,
        S_DIFF = 20'h01000,
        S_SQX  = 20'h02000,
        S_SQY  = 20'h04000,
        S_SQR  = 20'h08000,
        S_SQE  = 20'h10000,
        S_VEC  = 20'h20000,
        S_VECW = 20'h40000,
        S_EMIT = 20'h80000
    } t_state;

    t_state r_state;

    // Configuration
    logic [15:0]        r_thr;
    logic [11:0]        r_minb;
    logic [16:0]        r_exp;
    logic [16:0]        r_tol;
    logic signed [31:0] r_start;
    logic [29:0]        r_step;

    // Scan state
    logic [IW-1:0]      r_idx;
    logic               r_run;
    logic [1:0]         r_cs;
    logic signed [31:0] r_sx0, r_sx1, r_sy0, r_sy1;
    logic [IW-1:0]      r_n0, r_n1;

    // Per-beam work
    logic [15:0]   r_rng;
    logic          r_last;
    logic [PW-1:0] r_p;
    logic [KW-1:0] r_k;
    t_cw           r_m;
    logic          r_neg;
    t_cw           r_c, r_s;

    // End-of-scan work
    logic [1:0]         r_dsel;
    logic [32:0]        r_dq;
    logic [IW-1:0]      r_rem;
    logic [IW-1:0]      r_dn;
    logic               r_dneg;
    logic [5:0]         r_cnt;
    logic signed [17:0] r_cx0, r_cy0, r_cx1, r_cy1;
    logic signed [18:0] r_ea, r_eb;
    logic [37:0]        r_sr, r_sqq, r_sb;
    logic               r_ph;

    // Result word
    logic               r_ov;
    logic [1:0]         r_ost;
    logic [16:0]        r_osp;
    logic signed [16:0] r_omx, r_omy;
    logic [15:0]        r_odist;
    logic signed [31:0] r_oang;

    logic w_in_acc, w_out_acc, w_cfg_wr;

    assign w_in_acc  = i_valid & o_ready;
    assign w_out_acc = r_ov & i_ready;
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            REG_THR:   prdata = {16'd0, r_thr};
            REG_MINB:  prdata = {20'd0, r_minb};
            REG_EXP:   prdata = {15'd0, r_exp};
            REG_TOL:   prdata = {15'd0, r_tol};
            REG_START: prdata = r_start;
            REG_STEP:  prdata = {2'd0, r_step};
            default:   prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // Angle reduction helpers
    logic [PW+1:0] w_modc;
    t_cw           w_m0, w_m1, w_m2, w_fz;
    logic          w_fneg;

    always_comb begin
        w_modc = (PW + 2)'(32'd3373259426) << r_k;
        w_m0   = t_cw'(r_start) + t_cw'(r_p[31:0]);
        if (w_m0 < 0) begin
            w_m1 = w_m0 + C_2PI;
        end else if (w_m0 >= C_2PI) begin
            w_m1 = w_m0 - C_2PI;
        end else begin
            w_m1 = w_m0;
        end
        w_m2 = (w_m1 > C_PI) ? w_m1 - C_2PI : w_m1;
        if (r_m > C_HPI) begin
            w_fz   = r_m - C_PI;
            w_fneg = 1'b1;
        end else if (r_m < -C_HPI) begin
            w_fz   = r_m + C_PI;
            w_fneg = 1'b1;
        end else begin
            w_fz   = r_m;
            w_fneg = 1'b0;
        end
    end

    // Beam contribution: round(range * trig / 2^30)
    t_cw                w_mop;
    logic signed [52:0] w_prod, w_rnd;
    logic signed [31:0] w_ctb;

    always_comb begin
        w_mop  = (r_state == S_ACX) ? r_c : r_s;
        w_prod = $signed({1'b0, r_rng}) * w_mop;
        w_rnd  = w_prod + 53'sd536870912;
        w_ctb  = 32'(w_rnd >>> 30);
    end

    // Cluster test at scan end
    logic [1:0] w_tot;
    logic       w_ok;

    always_comb begin
        w_tot = r_cs + {1'b0, (r_run && r_cs != 2'd2)};
        w_ok  = (w_tot == 2'd2) && (CMW'(r_n0) >= CMW'(r_minb)) &&
                (CMW'(r_n1) >= CMW'(r_minb));
    end

    // Divider operand select and one restoring step
    logic signed [31:0] w_dsum;
    logic signed [32:0] w_dse;
    logic [32:0]        w_dabs;
    logic [IW-1:0]      w_dn;
    logic [IW:0]        w_rsh;
    logic               w_ge;
    logic signed [17:0] w_cq, w_cen;

    always_comb begin
        case (r_dsel)
            2'd0:    w_dsum = r_sx0;
            2'd1:    w_dsum = r_sy0;
            2'd2:    w_dsum = r_sx1;
            default: w_dsum = r_sy1;
        endcase
        w_dn   = r_dsel[1] ? r_n1 : r_n0;
        w_dse  = 33'(w_dsum);
        w_dabs = (w_dse < 0) ? 33'(-w_dse) : 33'(w_dse);
        w_rsh  = {r_rem, r_dq[32]};
        w_ge   = (w_rsh >= {1'b0, r_dn});
        w_cq   = $signed({1'b0, r_dq[16:0]});
        w_cen  = r_dneg ? -w_cq : w_cq;
    end

    // Squares, square-root step and rounding
    logic signed [18:0] w_sop;
    logic signed [37:0] w_sq;
    logic [37:0]        w_qb;
    logic [19:0]        w_root;
    logic [16:0]        w_sp;
    logic signed [18:0] w_dev, w_adev;

    always_comb begin
        w_sop  = (r_state == S_SQX) ? r_ea : r_eb;
        w_sq   = w_sop * w_sop;
        w_qb   = r_sqq + r_sb;
        w_root = r_sqq[19:0] + {19'd0, (r_sr > r_sqq)};
        w_sp   = (w_root > 20'd131071) ? 17'd131071 : w_root[16:0];
        w_dev  = $signed({2'b0, w_sp}) - $signed({2'b0, r_exp});
        w_adev = (w_dev < 0) ? -w_dev : w_dev;
    end

    // Midpoint: halve rounding away from zero, saturate
    logic signed [18:0] w_hx, w_hy, w_ax, w_ay;
    logic signed [18:0] w_rx, w_ry;
    logic signed [16:0] w_mx, w_my;

    always_comb begin
        w_hx = {r_cx0[17], r_cx0} + {r_cx1[17], r_cx1};
        w_hy = {r_cy0[17], r_cy0} + {r_cy1[17], r_cy1};
        w_ax = (w_hx < 0) ? -w_hx : w_hx;
        w_ay = (w_hy < 0) ? -w_hy : w_hy;
        w_rx = (w_ax + 19'sd1) >>> 1;
        w_ry = (w_ay + 19'sd1) >>> 1;
        w_rx = (w_hx < 0) ? -w_rx : w_rx;
        w_ry = (w_hy < 0) ? -w_ry : w_ry;
        if (w_rx > 19'sd65535) begin
            w_mx = 17'sd65535;
        end else if (w_rx < -19'sd65535) begin
            w_mx = -17'sd65535;
        end else begin
            w_mx = w_rx[16:0];
        end
        if (w_ry > 19'sd65535) begin
            w_my = 17'sd65535;
        end else if (w_ry < -19'sd65535) begin
            w_my = -17'sd65535;
        end else begin
            w_my = w_ry[16:0];
        end
    end

    // Shared CORDIC unit: rotation for sine/cosine, vectoring for the angle
    t_cord_req w_req;
    t_cw       w_cx, w_cy, w_cz, w_vx0, w_vy0;
    t_cw       w_ox, w_oy, w_oz, w_az;
    logic      w_cdone;

    always_comb begin
        w_vx0     = t_cw'(r_omx) <<< 12;
        w_vy0     = t_cw'(r_omy) <<< 12;
        w_req.start = (r_state == S_ROT) || (r_state == S_VEC);
        w_req.vec   = (r_state == S_VEC);
        if (r_state == S_VEC) begin
            if (w_vx0 < 0) begin
                w_cx = -w_vx0;
                w_cy = -w_vy0;
                w_cz = (w_vy0 >= 0) ? C_PI : -C_PI;
            end else begin
                w_cx = w_vx0;
                w_cy = w_vy0;
                w_cz = '0;
            end
        end else begin
            w_cx = C_K;
            w_cy = '0;
            w_cz = w_fz;
        end
        if (w_oz > C_PI) begin
            w_az = C_PI;
        end else if (w_oz < -C_PI) begin
            w_az = -C_PI;
        end else begin
            w_az = w_oz;
        end
    end

    scrp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_z     (w_cz),
        .o_done  (w_cdone),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_z     (w_oz)
    );

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_thr   <= RST_THR;
            r_minb  <= RST_MINB;
            r_exp   <= RST_EXP;
            r_tol   <= RST_TOL;
            r_start <= RST_START;
            r_step  <= RST_STEP;
            r_idx   <= '0;
            r_run   <= 1'b0;
            r_cs    <= 2'd0;
            r_sx0   <= '0;
            r_sx1   <= '0;
            r_sy0   <= '0;
            r_sy1   <= '0;
            r_n0    <= '0;
            r_n1    <= '0;
        end else begin
            // drop the result word once taken
            if (w_out_acc) begin
                r_ov <= 1'b0;
            end

            // configuration write
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_THR:   r_thr   <= pwdata[15:0];
                    REG_MINB:  r_minb  <= pwdata[11:0];
                    REG_EXP:   r_exp   <= pwdata[16:0];
                    REG_TOL:   r_tol   <= pwdata[16:0];
                    REG_START: r_start <= pwdata;
                    REG_STEP:  r_step  <= pwdata[29:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_rng  <= i_range_mm;
                        r_last <= i_last_beam;
                        r_state <= i_last_beam ? S_EVAL : S_IDLE;
                        if (r_idx < IW'(MAX_BEAMS)) begin
                            if (i_intensity >= r_thr) begin
                                if (r_cs != 2'd2) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_run <= 1'b1;
                                    r_idx <= r_idx + 1'b1;
                                end
                            end else begin
                                if (r_run) begin
                                    r_run <= 1'b0;
                                    if (r_cs != 2'd2) begin
                                        r_cs <= r_cs + 2'd1;
                                    end
                                end
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_p     <= r_idx * r_step;
                    r_k     <= KW'(IW - 1);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    // subtract 2*pi scaled down one bit a step
                    if ({2'b00, r_p} >= w_modc) begin
                        r_p <= PW'({2'b00, r_p} - w_modc);
                    end
                    if (r_k == '0) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_FOLD: begin
                    r_m     <= w_m2;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_neg   <= w_fneg;
                    r_state <= S_ROTW;
                end
                S_ROTW: begin
                    if (w_cdone) begin
                        r_c     <= r_neg ? -w_ox : w_ox;
                        r_s     <= r_neg ? -w_oy : w_oy;
                        r_state <= S_ACX;
                    end
                end
                S_ACX: begin
                    if (r_cs[0]) begin
                        r_sx1 <= r_sx1 + w_ctb;
                    end else begin
                        r_sx0 <= r_sx0 + w_ctb;
                    end
                    r_state <= S_ACY;
                end
                S_ACY: begin
                    if (r_cs[0]) begin
                        r_sy1 <= r_sy1 + w_ctb;
                        r_n1  <= r_n1 + 1'b1;
                    end else begin
                        r_sy0 <= r_sy0 + w_ctb;
                        r_n0  <= r_n0 + 1'b1;
                    end
                    r_run   <= 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= r_last ? S_EVAL : S_IDLE;
                end
                S_EVAL: begin
                    // hold until the previous result word has gone
                    if (!r_ov || i_ready) begin
                        r_ost   <= ST_FEW;
                        r_osp   <= '0;
                        r_omx   <= '0;
                        r_omy   <= '0;
                        r_odist <= '0;
                        r_oang  <= '0;
                        r_dsel  <= 2'd0;
                        r_state <= w_ok ? S_DIVI : S_EMIT;
                    end
                end
                S_DIVI: begin
                    r_dneg  <= w_dsum[31];
                    r_dq    <= w_dabs + 33'(w_dn >> 1);
                    r_dn    <= w_dn;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    r_rem <= w_ge ? IW'(w_rsh - {1'b0, r_dn}) : w_rsh[IW-1:0];
                    r_dq  <= {r_dq[31:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_state <= S_DIVE;
                    end
                end
                S_DIVE: begin
                    case (r_dsel)
                        2'd0:    r_cx0 <= w_cen;
                        2'd1:    r_cy0 <= w_cen;
                        2'd2:    r_cx1 <= w_cen;
                        default: r_cy1 <= w_cen;
                    endcase
                    r_dsel  <= r_dsel + 2'd1;
                    r_state <= (r_dsel == 2'd3) ? S_DIFF : S_DIVI;
                end
                S_DIFF: begin
                    r_ea    <= {r_cx1[17], r_cx1} - {r_cx0[17], r_cx0};
                    r_eb    <= {r_cy1[17], r_cy1} - {r_cy0[17], r_cy0};
                    r_ph    <= 1'b0;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_sr    <= w_sq;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sr    <= r_sr + w_sq;
                    r_sqq   <= '0;
                    r_sb    <= 38'd1 << 36;
                    r_cnt   <= '0;
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    if (r_sr >= w_qb) begin
                        r_sr  <= r_sr - w_qb;
                        r_sqq <= (r_sqq >> 1) + r_sb;
                    end else begin
                        r_sqq <= r_sqq >> 1;
                    end
                    r_sb  <= r_sb >> 2;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd18) begin
                        r_state <= S_SQE;
                    end
                end
                S_SQE: begin
                    if (!r_ph) begin
                        r_osp <= w_sp;
                        if (w_adev <= $signed({2'b0, r_tol})) begin
                            r_ost   <= ST_FOUND;
                            r_omx   <= w_mx;
                            r_omy   <= w_my;
                            r_ea    <= 19'(w_mx);
                            r_eb    <= 19'(w_my);
                            r_ph    <= 1'b1;
                            r_state <= S_SQX;
                        end else begin
                            r_ost   <= ST_SPACING;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_odist <= (w_root > 20'd65535) ? 16'd65535 : w_root[15:0];
                        if (r_omy == '0) begin
                            r_oang  <= (r_omx < 0) ? 32'(C_PI) : 32'd0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_VEC;
                        end
                    end
                end
                S_VEC: begin
                    r_state <= S_VECW;
                end
                S_VECW: begin
                    if (w_cdone) begin
                        r_oang  <= w_az[31:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // show the result word and clear the scan
                    r_ov    <= 1'b1;
                    r_idx   <= '0;
                    r_run   <= 1'b0;
                    r_cs    <= 2'd0;
                    r_sx0   <= '0;
                    r_sx1   <= '0;
                    r_sy0   <= '0;
                    r_sy1   <= '0;
                    r_n0    <= '0;
                    r_n1    <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready                = (r_state == S_IDLE);
    assign o_valid                = r_ov;
    assign o_legs_found           = (r_ost == ST_FOUND);
    assign o_status               = r_ost;
    assign o_leg_spacing_mm       = r_osp;
    assign o_midpoint_x_mm        = r_omx;
    assign o_midpoint_y_mm        = r_omy;
    assign o_midpoint_distance_mm = r_odist;
    assign o_midpoint_angle       = r_oang;

    // A result without a found pair carries no midpoint
    a_no_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |->
        (o_midpoint_x_mm == '0 && o_midpoint_y_mm == '0 &&
         o_midpoint_distance_mm == '0 && o_midpoint_angle == '0))
        else $error("midpoint set without a found pair");

    // Too few clusters gives no spacing
    a_few_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FEW) |-> (o_leg_spacing_mm == '0))
        else $error("spacing set with too few clusters");

    // CORDIC finishes only while the sequencer waits for it
    a_cdone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == S_ROTW || r_state == S_VECW))
        else $error("CORDIC result outside a wait state");

    // Closed cluster count saturates at two
    a_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cs != 2'd3)
        else $error("cluster count past two");

endmodule
